/* rtl/scld_pkg.sv */
package scld_pkg;

    // line and command geometry
    localparam int LINE_CHARS_DEF = 32;
    localparam int CMD_COUNT      = 8;
    localparam int CMD_MAXLEN     = 13;
    localparam int CMD_POS_W      = 4;
    localparam int RATE_W         = 10;
    localparam int CFG_IDX_W      = 1;

    localparam logic [RATE_W-1:0] RATE_SAT     = 10'd1023;
    localparam logic [RATE_W-1:0] MIN_RATE_RST = 10'd1;
    localparam logic [RATE_W-1:0] MAX_RATE_RST = 10'd500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'b1;

    // received byte codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // result kinds
    typedef enum logic [2:0] {
        K_ECHO      = 3'd0,
        K_COMMAND   = 3'd1,
        K_RANGE_ERR = 3'd2,
        K_FMT_ERR   = 3'd3,
        K_UNKNOWN   = 3'd4,
        K_OVERFLOW  = 3'd5
    } t_kind;

    // command codes, in match priority order
    typedef enum logic [2:0] {
        CMD_RATE     = 3'd0,
        CMD_CONSTANT = 3'd1,
        CMD_RAMP     = 3'd2,
        CMD_START    = 3'd3,
        CMD_STOP     = 3'd4,
        CMD_PAUSE    = 3'd5,
        CMD_RESUME   = 3'd6,
        CMD_ALM_CLR  = 3'd7
    } t_cmd;

    // control from the sequencer to the match unit
    typedef struct packed {
        logic                 clear;
        logic                 step;
        logic [CMD_POS_W-1:0] pos;
        logic                 beyond;
    } t_match_ctl;

    // command text, left aligned, zero padded
    function automatic logic [CMD_MAXLEN*8-1:0] cmd_text(input logic [2:0] idx);
        logic [CMD_MAXLEN*8-1:0] t;
        case (idx)
            CMD_RATE:        t = {"SET_", "RATE ", 32'h0};
            CMD_CONSTANT:    t = {"MODE_", "CONSTANT"};
            CMD_RAMP:        t = {"MODE_", "RAMP", 32'h0};
            CMD_START:       t = {"START", 64'h0};
            CMD_STOP:        t = {"STOP", 72'h0};
            CMD_PAUSE:       t = {"PAUSE", 64'h0};
            CMD_RESUME:      t = {"RESUME", 56'h0};
            default:         t = {"ALARM_", "CLEAR", 16'h0};
        endcase
        return t;
    endfunction

    function automatic logic [CMD_POS_W-1:0] cmd_len(input logic [2:0] idx);
        logic [CMD_POS_W-1:0] l;
        case (idx)
            CMD_RATE:        l = 4'd9;
            CMD_CONSTANT:    l = 4'd13;
            CMD_RAMP:        l = 4'd9;
            CMD_START:       l = 4'd5;
            CMD_STOP:        l = 4'd4;
            CMD_PAUSE:       l = 4'd5;
            CMD_RESUME:      l = 4'd6;
            default:         l = 4'd11;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] cmd_char(input logic [2:0] idx,
                                            input logic [CMD_POS_W-1:0] pos);
        logic [CMD_MAXLEN*8-1:0] t;
        logic [7:0]              c;
        t = cmd_text(idx);
        if (int'(pos) >= CMD_MAXLEN) begin
            c = 8'h0;
        end else begin
            c = t[(CMD_MAXLEN-1-int'(pos))*8 +: 8];
        end
        return c;
    endfunction

endpackage

/* rtl/serial_command_line_decoder.sv */
// channel   | valid       | ready       | payload
// ----------+-------------+-------------+------------------------------------------
// rx        | i_rx_valid  | o_rx_ready  | i_rx_byte
// result    | o_res_valid | i_res_ready | o_kind o_echo_byte o_command o_rate_value o_last
// config    | i_cfg_we    | (none)      | i_cfg_idx i_cfg_data
//
// a printable byte yields an echo beat (and an overflow beat when it overflows the line),
// backspace yields BS, space, BS echo beats, ignored bytes none; beats wait on the output
// line end: a match walk over the line memory (read, then compare, at each position), then
// the select; for the rate command the argument parse then reads and evaluates each line
// position up to the one that stops it, followed by the range check
// synchronous active-low reset; line memory contents are not cleared
// o_rx_ready is low while a byte is worked on; a stalled result only delays the sequencer
module serial_command_line_decoder import scld_pkg::*; #(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_echo_byte,
    output logic [2:0]           o_command,
    output logic [RATE_W-1:0]    o_rate_value,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RATE_W-1:0]    i_cfg_data
);

    localparam int LW = $clog2(LINE_CHARS);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_ECHO     = 12'b000000000010,
        S_OVF      = 12'b000000000100,
        S_BS1      = 12'b000000001000,
        S_BS2      = 12'b000000010000,
        S_BS3      = 12'b000000100000,
        S_WALK_RD  = 12'b000001000000,
        S_WALK_CMP = 12'b000010000000,
        S_SEL      = 12'b000100000000,
        S_PARSE_RD = 12'b001000000000,
        S_PARSE_EV = 12'b010000000000,
        S_CHECK    = 12'b100000000000
    } t_state;

    // S_RESULT is folded into the emit arms below through r_res_pend
    t_state r_state, n_state;

    logic [6:0]        r_line [LINE_CHARS];
    logic [6:0]        r_rd;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_pos, n_pos;
    logic [7:0]        r_byte;
    logic              r_ovf, n_ovf;
    logic              r_neg, n_neg;
    logic              r_digit, n_digit;
    logic              r_phase, n_phase;
    logic              r_res_pend, n_res_pend;
    logic [RATE_W-1:0] r_acc, n_acc;
    logic [RATE_W-1:0] r_min_rate, r_max_rate;

    t_kind             r_res_kind, n_res_kind;
    logic [2:0]        r_res_cmd, n_res_cmd;
    logic [RATE_W-1:0] r_res_rate, n_res_rate;

    logic              r_out_valid, n_out_valid;
    t_kind             r_kind, n_kind;
    logic [7:0]        r_echo, n_echo;
    logic [2:0]        r_cmd, n_cmd;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic              r_last, n_last;

    logic              w_accept;
    logic              w_slot;
    logic              w_store_we;
    logic              w_rd_en;
    logic              w_beyond;
    logic [7:0]        w_ch;
    logic              w_is_digit;
    logic [13:0]       w_acc_prod;
    logic              w_hit;
    logic [2:0]        w_sel;
    t_match_ctl        w_mctl;

    assign o_rx_ready = (r_state == S_IDLE) && !r_res_pend;
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_slot     = !r_out_valid || i_res_ready;
    assign w_beyond   = r_pos >= r_len;
    assign w_ch       = {1'b0, r_rd};
    assign w_is_digit = (w_ch >= CH_ZERO) && (w_ch <= CH_NINE);
    assign w_acc_prod = 14'({r_acc, 3'b000}) + 14'({r_acc, 1'b0}) + 14'(r_rd[3:0]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate <= MIN_RATE_RST;
            r_max_rate <= MAX_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RATE: r_min_rate <= i_cfg_data;
                CFG_MAX_RATE: r_max_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_line[r_len] <= i_rx_byte[6:0];
        end
        if (w_rd_en) begin
            r_rd <= r_line[r_pos];
        end
    end

    assign w_mctl.clear  = (r_state == S_IDLE);
    assign w_mctl.step   = (r_state == S_WALK_CMP);
    assign w_mctl.pos    = r_pos[CMD_POS_W-1:0];
    assign w_mctl.beyond = w_beyond;

    scld_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_char  (r_rd),
        .o_hit   (w_hit),
        .o_sel   (w_sel)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_neg       = r_neg;
        n_digit     = r_digit;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_res_pend  = r_res_pend;
        n_res_kind  = r_res_kind;
        n_res_cmd   = r_res_cmd;
        n_res_rate  = r_res_rate;
        n_out_valid = r_out_valid && !i_res_ready;
        n_kind      = r_kind;
        n_echo      = r_echo;
        n_cmd       = r_cmd;
        n_rate      = r_rate;
        n_last      = r_last;
        w_store_we  = 1'b0;
        w_rd_en     = 1'b0;

        unique case (r_state) inside
            S_IDLE: begin
                if (r_res_pend) begin
                    // final decode result of a line
                    if (w_slot) begin
                        n_out_valid = 1'b1;
                        n_kind      = r_res_kind;
                        n_echo      = '0;
                        n_cmd       = r_res_cmd;
                        n_rate      = r_res_rate;
                        n_last      = 1'b1;
                        n_res_pend  = 1'b0;
                        n_len       = '0;
                    end
                end else if (w_accept) begin
                    if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
                        if (r_len != '0) begin
                            n_pos   = '0;
                            n_state = S_WALK_RD;
                        end
                    end else if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                        if (r_len != '0) begin
                            n_len   = r_len - 1'b1;
                            n_state = S_BS1;
                        end
                    end else if (i_rx_byte >= CH_SPACE && i_rx_byte <= CH_TILDE) begin
                        n_state = S_ECHO;
                        if (r_len < LW'(LINE_CHARS-1)) begin
                            w_store_we = 1'b1;
                            n_len      = r_len + 1'b1;
                            n_ovf      = 1'b0;
                        end else begin
                            n_len = '0;
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
            S_ECHO: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_kind      = K_ECHO;
                    n_echo      = r_byte;
                    n_cmd       = '0;
                    n_rate      = '0;
                    n_last      = !r_ovf;
                    n_state     = r_ovf ? S_OVF : S_IDLE;
                end
            end
            S_OVF: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_kind      = K_OVERFLOW;
                    n_echo      = '0;
                    n_cmd       = '0;
                    n_rate      = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_BS1, S_BS2, S_BS3: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_kind      = K_ECHO;
                    n_echo      = (r_state == S_BS2) ? CH_SPACE : CH_BS;
                    n_cmd       = '0;
                    n_rate      = '0;
                    n_last      = (r_state == S_BS3);
                    n_state     = (r_state == S_BS1) ? S_BS2 :
                                  (r_state == S_BS2) ? S_BS3 : S_IDLE;
                end
            end
            // match walk: read one character, then narrow the candidates
            S_WALK_RD: begin
                w_rd_en = 1'b1;
                n_state = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                if (r_pos == LW'(CMD_MAXLEN-1)) begin
                    n_state = S_SEL;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_SEL: begin
                n_res_rate = '0;
                n_res_cmd  = '0;
                if (!w_hit) begin
                    n_res_kind = K_UNKNOWN;
                    n_res_pend = 1'b1;
                    n_state    = S_IDLE;
                end else if (w_sel != CMD_RATE) begin
                    n_res_kind = K_COMMAND;
                    n_res_cmd  = w_sel;
                    n_res_pend = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_pos   = LW'(cmd_len(CMD_RATE));
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_digit = 1'b0;
                    n_phase = 1'b0;
                    n_state = S_PARSE_RD;
                end
            end
            // argument parse: spaces, optional sign, digits
            S_PARSE_RD: begin
                w_rd_en = 1'b1;
                n_state = S_PARSE_EV;
            end
            S_PARSE_EV: begin
                if (w_beyond) begin
                    n_state = S_CHECK;
                end else if (!r_phase) begin
                    if (w_ch == CH_SPACE) begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_PARSE_RD;
                    end else if (w_ch == CH_MINUS || w_ch == CH_PLUS) begin
                        n_neg   = (w_ch == CH_MINUS);
                        n_phase = 1'b1;
                        n_pos   = r_pos + 1'b1;
                        n_state = S_PARSE_RD;
                    end else begin
                        n_phase = 1'b1;
                    end
                end else if (w_is_digit) begin
                    n_acc   = (w_acc_prod > 14'(RATE_SAT)) ? RATE_SAT : w_acc_prod[RATE_W-1:0];
                    n_digit = 1'b1;
                    n_pos   = r_pos + 1'b1;
                    n_state = S_PARSE_RD;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res_cmd  = CMD_RATE;
                n_res_rate = '0;
                if (!r_digit) begin
                    n_res_kind = K_FMT_ERR;
                end else if ((r_neg && r_acc != '0) || r_acc < r_min_rate ||
                             r_acc > r_max_rate) begin
                    n_res_kind = K_RANGE_ERR;
                end else begin
                    n_res_kind = K_COMMAND;
                    n_res_rate = r_acc;
                end
                n_res_pend = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_res_pend  <= n_res_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_rx_byte;
        end
        r_pos      <= n_pos;
        r_ovf      <= n_ovf;
        r_neg      <= n_neg;
        r_digit    <= n_digit;
        r_phase    <= n_phase;
        r_acc      <= n_acc;
        r_res_kind <= n_res_kind;
        r_res_cmd  <= n_res_cmd;
        r_res_rate <= n_res_rate;
        r_kind     <= n_kind;
        r_echo     <= n_echo;
        r_cmd      <= n_cmd;
        r_rate     <= n_rate;
        r_last     <= n_last;
    end

    assign o_res_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_echo_byte  = r_echo;
    assign o_command    = r_cmd;
    assign o_rate_value = r_rate;
    assign o_last       = r_last;

endmodule

/* rtl/scld_match.sv */
module scld_match import scld_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_match_ctl i_ctl,
    input  logic [6:0] i_char,
    output logic       o_hit,
    output logic [2:0] o_sel
);

    logic [CMD_COUNT-1:0] r_mask;
    logic [CMD_COUNT-1:0] n_mask;

    // drop every candidate whose text differs at this position
    always_comb begin
        n_mask = r_mask;
        if (i_ctl.clear) begin
            n_mask = '1;
        end else if (i_ctl.step) begin
            for (int i = 0; i < CMD_COUNT; i++) begin
                if (i_ctl.pos < cmd_len(3'(i)) &&
                    (i_ctl.beyond || {1'b0, i_char} != cmd_char(3'(i), i_ctl.pos))) begin
                    n_mask[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
        end else begin
            r_mask <= n_mask;
        end
    end

    // first surviving candidate in list order wins
    always_comb begin
        o_sel = '0;
        for (int i = CMD_COUNT-1; i >= 0; i--) begin
            if (r_mask[i]) begin
                o_sel = 3'(i);
            end
        end
    end

    assign o_hit = |r_mask;

endmodule

/* rtl/scld_checker.sv */
module scld_checker import scld_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [2:0]        i_kind,
    input logic [7:0]        i_echo_byte,
    input logic [2:0]        i_command,
    input logic [RATE_W-1:0] i_rate_value,
    input logic              i_last
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_kind) &&
        $stable(i_echo_byte) && $stable(i_command) && $stable(i_rate_value) &&
        $stable(i_last))
        else $error("result beat changed while stalled");

    // only echo beats carry a byte
    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kind != K_ECHO |-> i_echo_byte == 8'h0)
        else $error("echo byte on a non-echo beat");

    // every non-echo result closes the byte's result group
    a_last_nonecho: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kind != K_ECHO |-> i_last)
        else $error("non-echo beat not marked last");

    // a rate only comes with a decoded set rate command
    a_rate_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_rate_value != '0 |-> i_kind == K_COMMAND &&
        i_command == CMD_RATE)
        else $error("rate value outside a set rate command");

endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .i_kind       (o_kind),
    .i_echo_byte  (o_echo_byte),
    .i_command    (o_command),
    .i_rate_value (o_rate_value),
    .i_last       (o_last)
);

/* bench/line_decoder_checker.sv */
`timescale 1ns / 1ps

module line_decoder_checker
    import scld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  logic              i_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [2:0]        i_kind,
    input  logic [7:0]        i_echo_byte,
    input  logic [2:0]        i_command,
    input  logic [RATE_W-1:0] i_rate_value,
    input  logic              i_last,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RATE_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_results_due
);

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        echo_byte;
        t_cmd              command;
        logic [RATE_W-1:0] rate_value;
        logic              last;
    } t_line_result;

    // shadow of the edit line and the rate window
    logic [6:0]        line_chars [LINE_CHARS_DEF];
    int                line_len;
    logic [RATE_W-1:0] rate_floor;
    logic [RATE_W-1:0] rate_ceiling;
    t_line_result      due_results [$];
    int                mismatches;

    function automatic string command_word(input int idx);
        string w;
        case (idx)
            CMD_RATE:        w = {string'("SET_"), "RATE "};
            CMD_CONSTANT:    w = {string'("MODE_"), "CONSTANT"};
            CMD_RAMP:        w = {string'("MODE_"), "RAMP"};
            CMD_START:       w = "START";
            CMD_STOP:        w = "STOP";
            CMD_PAUSE:       w = "PAUSE";
            CMD_RESUME:      w = "RESUME";
            default:         w = {string'("ALARM_"), "CLEAR"};
        endcase
        return w;
    endfunction

    function automatic t_line_result make_result(input t_kind kind, input logic [7:0] echo,
                                                 input t_cmd cmd,
                                                 input logic [RATE_W-1:0] rate);
        t_line_result r;
        r.kind       = kind;
        r.echo_byte  = echo;
        r.command    = cmd;
        r.rate_value = rate;
        r.last       = 1'b0;
        return r;
    endfunction

    // prefix match in priority order, then the argument of the rate command
    function automatic t_line_result match_line();
        t_line_result r;
        string        w;
        int           sel;
        int           pos;
        int           acc;
        bit           neg;
        bit           seen_digit;
        bit           hit;
        sel = -1;
        for (int k = 0; k < CMD_COUNT && sel < 0; k++) begin
            w = command_word(k);
            if (line_len >= w.len()) begin
                hit = 1'b1;
                for (int p = 0; p < w.len(); p++) begin
                    if (line_chars[p] != w.getc(p)) hit = 1'b0;
                end
                if (hit) sel = k;
            end
        end
        if (sel < 0) begin
            r = make_result(K_UNKNOWN, 8'd0, CMD_RATE, '0);
        end else if (sel != CMD_RATE) begin
            r = make_result(K_COMMAND, 8'd0, t_cmd'(sel), '0);
        end else begin
            pos        = command_word(CMD_RATE).len();
            acc        = 0;
            neg        = 1'b0;
            seen_digit = 1'b0;
            while (pos < line_len && line_chars[pos] == CH_SPACE) pos++;
            if (pos < line_len && (line_chars[pos] == CH_MINUS || line_chars[pos] == CH_PLUS))
            begin
                neg = (line_chars[pos] == CH_MINUS);
                pos++;
            end
            while (pos < line_len && line_chars[pos] >= CH_ZERO && line_chars[pos] <= CH_NINE)
            begin
                seen_digit = 1'b1;
                acc = acc * 10 + (int'(line_chars[pos]) - int'(CH_ZERO));
                if (acc > int'(RATE_SAT)) acc = int'(RATE_SAT);
                pos++;
            end
            if (!seen_digit) begin
                r = make_result(K_FMT_ERR, 8'd0, CMD_RATE, '0);
            end else if ((neg && acc != 0) || acc < int'(rate_floor) ||
                         acc > int'(rate_ceiling)) begin
                r = make_result(K_RANGE_ERR, 8'd0, CMD_RATE, '0);
            end else begin
                r = make_result(K_COMMAND, 8'd0, CMD_RATE, acc[RATE_W-1:0]);
            end
        end
        line_len = 0;
        return r;
    endfunction

    // one received byte: edit the shadow line and queue what it causes
    task automatic decode_rx_byte(input logic [7:0] rx);
        t_line_result batch [$];
        t_line_result r;
        if (rx == CH_CR || rx == CH_LF) begin
            if (line_len > 0) batch.push_back(match_line());
        end else if (rx == CH_BS || rx == CH_DEL) begin
            if (line_len > 0) begin
                line_len--;
                batch.push_back(make_result(K_ECHO, CH_BS, CMD_RATE, '0));
                batch.push_back(make_result(K_ECHO, CH_SPACE, CMD_RATE, '0));
                batch.push_back(make_result(K_ECHO, CH_BS, CMD_RATE, '0));
            end
        end else if (rx >= CH_SPACE && rx <= CH_TILDE) begin
            batch.push_back(make_result(K_ECHO, rx, CMD_RATE, '0));
            if (line_len < LINE_CHARS_DEF - 1) begin
                line_chars[line_len] = rx[6:0];
                line_len++;
            end else begin
                line_len = 0;
                batch.push_back(make_result(K_OVERFLOW, 8'd0, CMD_RATE, '0));
            end
        end
        foreach (batch[i]) begin
            r      = batch[i];
            r.last = (i == batch.size() - 1);
            due_results.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [9:0] want,
                                 input logic [9:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        t_line_result want;
        if (due_results.size() == 0) begin
            $write("%0t: expected no result, got kind %0d echo %0d",
                   $time, i_kind, i_echo_byte);
            $display(" cmd %0d rate %0d last %0d", i_command, i_rate_value, i_last);
            mismatches++;
        end else begin
            want = due_results.pop_front();
            compare_field("kind", want.kind, i_kind);
            compare_field("echo_byte", want.echo_byte, i_echo_byte);
            compare_field("command", want.command, i_command);
            compare_field("rate_value", want.rate_value, i_rate_value);
            compare_field("last", want.last, i_last);
        end
    endtask

    // watch all three channels on each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_len     = 0;
            rate_floor   = MIN_RATE_RST;
            rate_ceiling = MAX_RATE_RST;
            mismatches   = 0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_RATE: rate_floor   = i_cfg_data;
                    default:      rate_ceiling = i_cfg_data;
                endcase
            end
            if (i_rx_valid && i_rx_ready) decode_rx_byte(i_rx_byte);
            if (i_res_valid && i_res_ready) check_result();
        end
        o_fail_count  <= mismatches;
        o_results_due <= due_results.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import scld_pkg::*;

    localparam int SETTLE_CYCLES = 128;
    localparam int PHASES        = 6;

    typedef enum int {
        SHAPE_COMMAND,
        SHAPE_RATE,
        SHAPE_RATE_NO_DIGIT,
        SHAPE_RATE_HUGE,
        SHAPE_PARTIAL,
        SHAPE_JUNK,
        SHAPE_EDITED,
        SHAPE_OVERFLOW,
        SHAPE_NOISE,
        SHAPE_COUNT
    } t_line_shape;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_rx_valid   = 1'b0;
    logic                 o_rx_ready;
    logic [7:0]           i_rx_byte    = 8'd0;
    logic                 o_res_valid;
    logic                 i_res_ready  = 1'b0;
    logic [2:0]           o_kind;
    logic [7:0]           o_echo_byte;
    logic [2:0]           o_command;
    logic [RATE_W-1:0]    o_rate_value;
    logic                 o_last;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [RATE_W-1:0]    i_cfg_data   = '0;

    int         fail_count;
    int         results_due;
    bit         calm = 1'b0;
    int         sent_bytes = 0;
    int         line_count = 0;
    int         cfg_min = MIN_RATE_RST;
    int         cfg_max = MAX_RATE_RST;
    logic [7:0] line_bytes [$];

    serial_command_line_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_kind       (o_kind),
        .o_echo_byte  (o_echo_byte),
        .o_command    (o_command),
        .o_rate_value (o_rate_value),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    line_decoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .i_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .i_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .i_kind        (o_kind),
        .i_echo_byte   (o_echo_byte),
        .i_command     (o_command),
        .i_rate_value  (o_rate_value),
        .i_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side stalls about 15 percent of cycles unless calm
    always @(posedge i_clk) begin
        i_res_ready <= calm || ($urandom_range(99) >= 15);
    end

    function automatic string command_word(input int idx);
        string w;
        case (idx)
            CMD_RATE:        w = {string'("SET_"), "RATE "};
            CMD_CONSTANT:    w = {string'("MODE_"), "CONSTANT"};
            CMD_RAMP:        w = {string'("MODE_"), "RAMP"};
            CMD_START:       w = "START";
            CMD_STOP:        w = "STOP";
            CMD_PAUSE:       w = "PAUSE";
            CMD_RESUME:      w = "RESUME";
            default:         w = {string'("ALARM_"), "CLEAR"};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CH_TILDE, CH_SPACE));
    endfunction

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) line_bytes.push_back(s.getc(k));
    endtask

    // one rx beat, with random gaps ahead of it
    task automatic send_rx(input logic [7:0] rx);
        if (!calm) begin
            while ($urandom_range(99) < 15) begin
                i_rx_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_line();
        foreach (line_bytes[k]) send_rx(line_bytes[k]);
        line_bytes.delete();
    endtask

    // drain every result, then give the block time to finish silent bytes
    task automatic settle();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_rates(input int lo, input int hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_RATE;
        i_cfg_data <= RATE_W'(lo);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_RATE;
        i_cfg_data <= RATE_W'(hi);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_min = lo;
        cfg_max = hi;
    endtask

    task automatic phase_setting(input int p, output int lo, output int hi, output int budget);
        case (p)
            0:       begin lo = MIN_RATE_RST; hi = MAX_RATE_RST; budget = 20; end
            1:       begin lo = 0;    hi = 1000; budget = 30; end
            2:       begin lo = 1000; hi = 1000; budget = 20; end
            3:       begin lo = 0;    hi = 0;    budget = 20; end
            4:       begin lo = 37;   hi = 823;  budget = 25; end
            default: begin lo = 600;  hi = 200;  budget = 20; end
        endcase
    endtask

    // one line of random content; every shape shows up once before weighting kicks in
    task automatic build_line();
        t_line_shape shape;
        string       word;
        int          pick;
        int          value;
        int          cut;
        if (line_count < SHAPE_COUNT) begin
            shape = t_line_shape'(line_count);
        end else begin
            pick = $urandom_range(99);
            if (pick < 30)      shape = SHAPE_COMMAND;
            else if (pick < 55) shape = SHAPE_RATE;
            else if (pick < 62) shape = SHAPE_RATE_NO_DIGIT;
            else if (pick < 67) shape = SHAPE_RATE_HUGE;
            else if (pick < 74) shape = SHAPE_PARTIAL;
            else if (pick < 80) shape = SHAPE_JUNK;
            else if (pick < 90) shape = SHAPE_EDITED;
            else if (pick < 93) shape = SHAPE_OVERFLOW;
            else                shape = SHAPE_NOISE;
        end
        line_count++;
        case (shape)
            SHAPE_COMMAND: begin
                push_text(command_word($urandom_range(CMD_ALM_CLR, CMD_CONSTANT)));
                if ($urandom_range(3) == 0) begin
                    repeat ($urandom_range(3, 1)) line_bytes.push_back(printable());
                end
            end
            SHAPE_RATE: begin
                push_text(command_word(CMD_RATE));
                repeat ($urandom_range(2)) line_bytes.push_back(CH_SPACE);
                pick = $urandom_range(9);
                if (pick == 0) line_bytes.push_back(CH_PLUS);
                if (pick == 1) line_bytes.push_back(CH_MINUS);
                case ($urandom_range(5))
                    0:       value = cfg_min;
                    1:       value = cfg_max;
                    2:       value = (cfg_min > 0) ? cfg_min - 1 : 0;
                    3:       value = cfg_max + 1;
                    4:       value = $urandom_range(RATE_SAT);
                    default: value = $urandom_range(30);
                endcase
                push_text($sformatf("%0d", value));
                if ($urandom_range(3) == 0) line_bytes.push_back(printable());
            end
            SHAPE_RATE_NO_DIGIT: begin
                push_text(command_word(CMD_RATE));
                repeat ($urandom_range(2)) line_bytes.push_back(CH_SPACE);
                if ($urandom_range(1) != 0)
                    line_bytes.push_back(($urandom_range(1) != 0) ? CH_PLUS : CH_MINUS);
                if ($urandom_range(1) != 0) line_bytes.push_back(8'("A" + $urandom_range(25)));
            end
            SHAPE_RATE_HUGE: begin
                push_text(command_word(CMD_RATE));
                push_text($sformatf("%0d", $urandom_range(99999, RATE_SAT + 1)));
            end
            SHAPE_PARTIAL: begin
                word = command_word($urandom_range(CMD_ALM_CLR, CMD_RATE));
                cut  = $urandom_range(word.len() - 1, 1);
                for (int k = 0; k < cut; k++) line_bytes.push_back(word.getc(k));
            end
            SHAPE_JUNK: begin
                repeat ($urandom_range(10, 1)) line_bytes.push_back(printable());
            end
            SHAPE_EDITED: begin
                word = command_word($urandom_range(CMD_ALM_CLR, CMD_CONSTANT));
                cut  = $urandom_range(word.len());
                for (int k = 0; k < cut; k++) line_bytes.push_back(word.getc(k));
                line_bytes.push_back(printable());
                line_bytes.push_back(($urandom_range(1) != 0) ? CH_BS : CH_DEL);
                for (int k = cut; k < word.len(); k++) line_bytes.push_back(word.getc(k));
            end
            SHAPE_OVERFLOW: begin
                repeat (LINE_CHARS_DEF - 1 + $urandom_range(3, 1))
                    line_bytes.push_back(printable());
            end
            default: begin
                repeat ($urandom_range(4, 1)) line_bytes.push_back(8'($urandom_range(255)));
            end
        endcase
        line_bytes.push_back(($urandom_range(1) != 0) ? CH_CR : CH_LF);
    endtask

    // stimulus
    initial begin
        int lo;
        int hi;
        int budget;
        int first_byte;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, empty-line edits, trailing text, negative zero
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_BS);
        push_text("STOP~");
        line_bytes.push_back(CH_DEL);
        line_bytes.push_back(CH_SPACE);
        line_bytes.push_back(CH_LF);
        push_text({string'("SET_"), "RATE -0"});
        line_bytes.push_back(CH_CR);
        send_line();

        // random lines under several rate windows
        for (int p = 0; p < PHASES; p++) begin
            phase_setting(p, lo, hi, budget);
            if (p > 0) begin
                settle();
                set_rates(lo, hi);
            end
            calm = (p == 3);
            first_byte = sent_bytes;
            while (sent_bytes - first_byte < budget) begin
                build_line();
                send_line();
            end
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

/* serial_command_line_decoder.f */
rtl/scld_pkg.sv
rtl/scld_match.sv
rtl/serial_command_line_decoder.sv
rtl/scld_checker.sv
bench/line_decoder_checker.sv
bench/tb_top.sv
